// ----- rtl/bsfc_pkg.sv -----
// Package for the byte-stuffed frame codec.
// Frame constants, action and status codes, and the result and decode word types; no dependencies.
package bsfc_pkg;

    localparam int PAYLOAD_BYTES = 4;
    localparam int FRAME_LEN     = PAYLOAD_BYTES + 3;
    // scratch buffer in the encoder is a bit longer than the frame
    localparam int FB_DEPTH      = FRAME_LEN + 4;
    localparam int FB_W          = $clog2(FB_DEPTH);
    localparam int POS_W         = $clog2(PAYLOAD_BYTES + 3);

    localparam int FRAME_W = 56;
    localparam int VALUE_W = 16;
    localparam int STAT_W  = 2;
    localparam int RX_W    = 40;

    localparam logic ACT_ENCODE = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    localparam logic [7:0] BYTE_START = 8'hAA;
    localparam logic [7:0] BYTE_ESC_A = 8'hAB;
    localparam logic [7:0] BYTE_ESC_B = 8'hAC;
    localparam logic [7:0] BYTE_END   = 8'hFF;
    localparam logic [7:0] BYTE_ESC_F = 8'hFE;
    localparam logic [7:0] BYTE_ESC_D = 8'hFD;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [VALUE_W-1:0] decoded_value;
        logic [STAT_W-1:0]  status;
    } t_result;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [STAT_W-1:0]  status;
    } t_dec;

endpackage

// ----- rtl/bsfc_ifs.sv -----
// Valid/ready channel interfaces for the codec request and response words.
// Depends on bsfc_pkg for field widths.
interface bsfc_req_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [7:0]                   command;
    logic [bsfc_pkg::VALUE_W-1:0] send_value;
    logic [bsfc_pkg::RX_W-1:0]    rx_payload;

    modport source (output valid, action, command, send_value, rx_payload, input ready);
    modport sink   (input valid, action, command, send_value, rx_payload, output ready);
endinterface

interface bsfc_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bsfc_pkg::FRAME_W-1:0] frame;
    logic [bsfc_pkg::VALUE_W-1:0] decoded_value;
    logic [bsfc_pkg::STAT_W-1:0]  status;

    modport source (output valid, frame, decoded_value, status, input ready);
    modport sink   (input valid, frame, decoded_value, status, output ready);
endinterface

// ----- rtl/bsfc_encoder.sv -----
// Frame builder: start byte, command, escaped value bytes, zero pad, end byte.
// Combinational; depends on bsfc_pkg.
module bsfc_encoder (
    input  logic [7:0]                   i_command,
    input  logic [bsfc_pkg::VALUE_W-1:0] i_send_value,
    output logic [bsfc_pkg::FRAME_W-1:0] o_frame
);

    function automatic logic [bsfc_pkg::FRAME_W-1:0] build_frame(
        input logic [7:0]                   cmd,
        input logic [bsfc_pkg::VALUE_W-1:0] sv
    );
        logic [7:0]                  fb [bsfc_pkg::FB_DEPTH];
        logic [bsfc_pkg::FB_W-1:0]   n;
        logic [7:0]                  b;
        logic [bsfc_pkg::FRAME_W-1:0] f;
        for (int i = 0; i < bsfc_pkg::FB_DEPTH; i++) begin
            fb[i] = 8'h00;
        end
        fb[0] = bsfc_pkg::BYTE_START;
        fb[1] = cmd;
        n = bsfc_pkg::FB_W'(2);
        for (int k = 0; k < 2; k++) begin
            b = (k == 0) ? sv[7:0] : sv[15:8];
            if (b == bsfc_pkg::BYTE_START) begin
                fb[n]      = bsfc_pkg::BYTE_ESC_A;
                fb[n + 1'b1] = bsfc_pkg::BYTE_ESC_A;
                n = n + bsfc_pkg::FB_W'(2);
            end else if (b == bsfc_pkg::BYTE_ESC_A) begin
                fb[n]      = bsfc_pkg::BYTE_ESC_A;
                fb[n + 1'b1] = bsfc_pkg::BYTE_ESC_B;
                n = n + bsfc_pkg::FB_W'(2);
            end else if (b == bsfc_pkg::BYTE_END) begin
                fb[n]      = bsfc_pkg::BYTE_ESC_F;
                fb[n + 1'b1] = bsfc_pkg::BYTE_ESC_F;
                n = n + bsfc_pkg::FB_W'(2);
            end else if (b == bsfc_pkg::BYTE_ESC_F) begin
                fb[n]      = bsfc_pkg::BYTE_ESC_F;
                fb[n + 1'b1] = bsfc_pkg::BYTE_ESC_D;
                n = n + bsfc_pkg::FB_W'(2);
            end else begin
                fb[n] = b;
                n = n + bsfc_pkg::FB_W'(1);
            end
        end
        // pad bytes are already zero; end byte closes the frame
        fb[bsfc_pkg::FRAME_LEN - 1] = bsfc_pkg::BYTE_END;
        f = '0;
        for (int i = 0; i < 7 && i < bsfc_pkg::FRAME_LEN; i++) begin
            f[i*8 +: 8] = fb[i];
        end
        return f;
    endfunction

    assign o_frame = build_frame(i_command, i_send_value);

endmodule

// ----- rtl/bsfc_decoder.sv -----
// Payload scanner: undoes escapes and checks start/end/escape rules.
// Combinational; depends on bsfc_pkg.
module bsfc_decoder (
    input  logic [bsfc_pkg::RX_W-1:0] i_rx_payload,
    output bsfc_pkg::t_dec            o_dec
);

    function automatic logic [7:0] rx_byte(
        input logic [63:0]                w,
        input logic [bsfc_pkg::POS_W-1:0] pos
    );
        logic [bsfc_pkg::POS_W:0] p;
        p = {1'b0, pos};
        if (p >= 8) begin
            return 8'h00;
        end
        return w[{p[2:0], 3'b000} +: 8];
    endfunction

    function automatic bsfc_pkg::t_dec scan(input logic [bsfc_pkg::RX_W-1:0] rx);
        logic [63:0]                w;
        logic [bsfc_pkg::POS_W-1:0] pos;
        logic                       done;
        logic [7:0]                 b;
        logic [7:0]                 nb;
        logic [7:0]                 outb;
        logic [7:0]                 g0;
        logic [7:0]                 g1;
        logic [1:0]                 cnt;
        bsfc_pkg::t_dec             r;
        w    = {{(64 - bsfc_pkg::RX_W){1'b0}}, rx};
        pos  = '0;
        done = 1'b0;
        g0   = 8'h00;
        g1   = 8'h00;
        cnt  = 2'd0;
        outb = 8'h00;
        nb   = 8'h00;
        r.value  = '0;
        r.status = bsfc_pkg::ST_RANGE;
        for (int it = 0; it <= bsfc_pkg::PAYLOAD_BYTES; it++) begin
            if (!done) begin
                b = rx_byte(w, pos);
                if (pos > bsfc_pkg::POS_W'(bsfc_pkg::PAYLOAD_BYTES)) begin
                    r.status = bsfc_pkg::ST_RANGE;
                    done     = 1'b1;
                end else if (pos == bsfc_pkg::POS_W'(bsfc_pkg::PAYLOAD_BYTES)
                             && b != bsfc_pkg::BYTE_END) begin
                    r.status = bsfc_pkg::ST_INVALID;
                    done     = 1'b1;
                end else if (b == bsfc_pkg::BYTE_START) begin
                    r.status = bsfc_pkg::ST_INVALID;
                    done     = 1'b1;
                end else if (b == bsfc_pkg::BYTE_END) begin
                    r.status = bsfc_pkg::ST_OK;
                    r.value  = {g1, g0};
                    done     = 1'b1;
                end else if (b == bsfc_pkg::BYTE_ESC_A || b == bsfc_pkg::BYTE_ESC_F) begin
                    // escape pair must fit before the end-byte slot
                    if ({1'b0, pos} + 1'b1 >= (bsfc_pkg::POS_W + 1)'(bsfc_pkg::PAYLOAD_BYTES)) begin
                        r.status = bsfc_pkg::ST_RANGE;
                        done     = 1'b1;
                    end else begin
                        nb = rx_byte(w, pos + 1'b1);
                        if (b == bsfc_pkg::BYTE_ESC_A) begin
                            if (nb != bsfc_pkg::BYTE_ESC_A && nb != bsfc_pkg::BYTE_ESC_B) begin
                                r.status = bsfc_pkg::ST_INVALID;
                                done     = 1'b1;
                            end
                            outb = (nb == bsfc_pkg::BYTE_ESC_A) ? bsfc_pkg::BYTE_START
                                                                : bsfc_pkg::BYTE_ESC_A;
                        end else begin
                            if (nb != bsfc_pkg::BYTE_ESC_F && nb != bsfc_pkg::BYTE_ESC_D) begin
                                r.status = bsfc_pkg::ST_INVALID;
                                done     = 1'b1;
                            end
                            outb = (nb == bsfc_pkg::BYTE_ESC_F) ? bsfc_pkg::BYTE_END
                                                                : bsfc_pkg::BYTE_ESC_F;
                        end
                        pos = pos + bsfc_pkg::POS_W'(2);
                    end
                end else begin
                    outb = b;
                    pos  = pos + bsfc_pkg::POS_W'(1);
                end
                if (!done) begin
                    if (cnt == 2'd0) begin
                        g0 = outb;
                    end else if (cnt == 2'd1) begin
                        g1 = outb;
                    end
                    if (cnt != 2'd2) begin
                        cnt = cnt + 2'd1;
                    end
                end
            end
        end
        return r;
    endfunction

    assign o_dec = scan(i_rx_payload);

endmodule

// ----- rtl/byte_stuffed_frame_codec_top.sv -----
// Top level of the byte-stuffed frame codec: input register, encoder/decoder, result register.
// Depends on bsfc_pkg, bsfc_ifs, bsfc_encoder and bsfc_decoder.
//
//  port   dir  words                        notes
//  i_req  in   action, command, send_value,  one request word per handshake
//              rx_payload
//  o_rsp  out  frame, decoded_value, status  one response word per request
//
// Two register stages: a request word is taken into the input register, the
// encode/decode logic runs between it and the result register, and the result
// is loaded into the result register and shown on o_rsp once that register is
// free. One word per cycle sustained while o_rsp is not stalled.
// i_req.ready drops only when both stages are full and o_rsp is stalled.
// Synchronous active-low reset clears the valid flags only.
module byte_stuffed_frame_codec_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bsfc_req_if.sink       i_req,
    bsfc_rsp_if.source     o_rsp
);

    logic                         r_s1_valid;
    logic                         r_s1_action;
    logic [7:0]                   r_s1_command;
    logic [bsfc_pkg::VALUE_W-1:0] r_s1_send_value;
    logic [bsfc_pkg::RX_W-1:0]    r_s1_rx_payload;

    logic                         r_out_valid;
    bsfc_pkg::t_result            r_out;
    bsfc_pkg::t_result            n_out;

    logic [bsfc_pkg::FRAME_W-1:0] enc_frame;
    bsfc_pkg::t_dec               dec_res;
    logic                         out_load;
    logic                         s1_load;

    bsfc_encoder u_enc (
        .i_command    (r_s1_command),
        .i_send_value (r_s1_send_value),
        .o_frame      (enc_frame)
    );

    bsfc_decoder u_dec (
        .i_rx_payload (r_s1_rx_payload),
        .o_dec        (dec_res)
    );

    assign out_load    = !r_out_valid || o_rsp.ready;
    assign i_req.ready = !r_s1_valid || out_load;
    assign s1_load     = i_req.valid && i_req.ready;

    always_comb begin
        if (r_s1_action == bsfc_pkg::ACT_DECODE) begin
            n_out.frame         = '0;
            n_out.decoded_value = dec_res.value;
            n_out.status        = dec_res.status;
        end else begin
            n_out.frame         = enc_frame;
            n_out.decoded_value = '0;
            n_out.status        = bsfc_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_s1_valid <= i_req.valid;
            end
            if (out_load) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_action     <= i_req.action;
            r_s1_command    <= i_req.command;
            r_s1_send_value <= i_req.send_value;
            r_s1_rx_payload <= i_req.rx_payload;
        end
        if (out_load && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.frame         = r_out.frame;
    assign o_rsp.decoded_value = r_out.decoded_value;
    assign o_rsp.status        = r_out.status;

endmodule

// ----- tb/sv/byte_stuffed_frame_codec_top_tb.sv -----
// Testbench for byte_stuffed_frame_codec_top: directed and random encode/decode words,
// checked against a local predictor. Depends on bsfc_pkg, bsfc_ifs and the codec RTL.
module byte_stuffed_frame_codec_top_tb;
    import bsfc_pkg::*;

    localparam int RAND_ITEMS   = 725;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 10;

    // Holds the expected response words and computes them from each accepted request.
    class frame_result_book;
        t_result expected_q[$];
        int errors = 0;
        int n_enc = 0;
        int n_dec = 0;
        int n_ok = 0;
        int n_inv = 0;
        int n_rng = 0;

        function t_result encode_frame(logic [7:0] cmd, logic [VALUE_W-1:0] sv);
            t_result res;
            logic [7:0] fq[$];
            logic [7:0] b;
            fq = {BYTE_START, cmd};
            for (int k = 0; k < 2; k++) begin
                b = (k == 0) ? sv[7:0] : sv[15:8];
                case (b)
                    BYTE_START: begin
                        fq.push_back(BYTE_ESC_A);
                        fq.push_back(BYTE_ESC_A);
                    end
                    BYTE_ESC_A: begin
                        fq.push_back(BYTE_ESC_A);
                        fq.push_back(BYTE_ESC_B);
                    end
                    BYTE_END: begin
                        fq.push_back(BYTE_ESC_F);
                        fq.push_back(BYTE_ESC_F);
                    end
                    BYTE_ESC_F: begin
                        fq.push_back(BYTE_ESC_F);
                        fq.push_back(BYTE_ESC_D);
                    end
                    default: fq.push_back(b);
                endcase
            end
            while (fq.size() < FRAME_LEN - 1)
                fq.push_back(8'h00);
            if (fq.size() > FRAME_LEN - 1)
                fq[FRAME_LEN-1] = BYTE_END;
            else
                fq.push_back(BYTE_END);
            res = '0;
            for (int i = 0; i < 7 && i < fq.size(); i++)
                res.frame[8*i +: 8] = fq[i];
            res.status = ST_OK;
            return res;
        endfunction

        function t_dec decode_payload(logic [RX_W-1:0] rx);
            t_dec d;
            logic [63:0] word;
            logic [7:0] b, nb, outb, got0, got1;
            int pos, cnt;
            bit done;
            word = 64'(rx);
            d.value = '0;
            d.status = ST_RANGE;
            pos = 0;
            cnt = 0;
            got0 = '0;
            got1 = '0;
            outb = '0;
            done = 0;
            for (int it = 0; it <= PAYLOAD_BYTES && !done; it++) begin
                if (pos > PAYLOAD_BYTES) begin
                    done = 1;
                end else begin
                    b = 8'(word >> (8 * pos));
                    if (pos == PAYLOAD_BYTES && b != BYTE_END) begin
                        d.status = ST_INVALID;
                        done = 1;
                    end else if (b == BYTE_START) begin
                        d.status = ST_INVALID;
                        done = 1;
                    end else if (b == BYTE_END) begin
                        d.value = {got1, got0};
                        d.status = ST_OK;
                        done = 1;
                    end else if (b == BYTE_ESC_A || b == BYTE_ESC_F) begin
                        if (pos + 1 >= PAYLOAD_BYTES) begin
                            d.status = ST_RANGE;
                            done = 1;
                        end else begin
                            nb = 8'(word >> (8 * (pos + 1)));
                            if (b == BYTE_ESC_A && nb == BYTE_ESC_A)
                                outb = BYTE_START;
                            else if (b == BYTE_ESC_A && nb == BYTE_ESC_B)
                                outb = BYTE_ESC_A;
                            else if (b == BYTE_ESC_F && nb == BYTE_ESC_F)
                                outb = BYTE_END;
                            else if (b == BYTE_ESC_F && nb == BYTE_ESC_D)
                                outb = BYTE_ESC_F;
                            else begin
                                d.status = ST_INVALID;
                                done = 1;
                            end
                            pos += 2;
                        end
                    end else begin
                        outb = b;
                        pos += 1;
                    end
                    if (!done) begin
                        if (cnt == 0)
                            got0 = outb;
                        else if (cnt == 1)
                            got1 = outb;
                        cnt++;
                    end
                end
            end
            return d;
        endfunction

        function void note_request(logic act, logic [7:0] cmd, logic [VALUE_W-1:0] sv,
                                   logic [RX_W-1:0] rx);
            t_result res;
            t_dec d;
            if (act == ACT_ENCODE) begin
                res = encode_frame(cmd, sv);
                n_enc++;
            end else begin
                d = decode_payload(rx);
                res = '0;
                res.status = d.status;
                res.decoded_value = (d.status == ST_OK) ? d.value : '0;
                n_dec++;
                case (d.status)
                    ST_OK:      n_ok++;
                    ST_INVALID: n_inv++;
                    default:    n_rng++;
                endcase
            end
            expected_q.push_back(res);
        endfunction

        function void check_response(t_result got);
            t_result exp_res;
            if (expected_q.size() == 0) begin
                $error("response word with no request outstanding: frame %h value %h status %0d",
                       got.frame, got.decoded_value, got.status);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (got.frame !== exp_res.frame) begin
                $error("frame: expected %h, got %h", exp_res.frame, got.frame);
                errors++;
            end
            if (got.decoded_value !== exp_res.decoded_value) begin
                $error("decoded_value: expected %h, got %h",
                       exp_res.decoded_value, got.decoded_value);
                errors++;
            end
            if (got.status !== exp_res.status) begin
                $error("status: expected %0d, got %0d", exp_res.status, got.status);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void report_leftover();
            if (expected_q.size() != 0) begin
                $error("%0d response words never arrived", expected_q.size());
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bsfc_req_if req_if();
    bsfc_rsp_if rsp_if();

    frame_result_book book;
    bit quiet = 0;
    bit hold_off_req = 0;

    byte_stuffed_frame_codec_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // biased toward the framing and escape bytes
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return BYTE_START;
            1: return BYTE_ESC_A;
            2: return BYTE_ESC_F;
            3: return BYTE_END;
            4: return BYTE_ESC_B;
            5: return BYTE_ESC_D;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [RX_W-1:0] rand_rx();
        return RX_W'({$urandom, $urandom});
    endfunction

    // Mostly well-formed payloads: escaped data bytes then an end byte, rest random.
    function automatic logic [RX_W-1:0] make_payload();
        logic [RX_W-1:0] w;
        logic [7:0] b;
        int pos, nd, r;
        w = rand_rx();
        r = $urandom_range(0, 9);
        if (r == 0)
            return w;
        pos = 0;
        nd = $urandom_range(0, PAYLOAD_BYTES);
        for (int i = 0; i < nd && pos < PAYLOAD_BYTES; i++) begin
            b = pick_byte();
            if (b == BYTE_START || b == BYTE_ESC_A || b == BYTE_END || b == BYTE_ESC_F) begin
                if (pos + 1 < PAYLOAD_BYTES) begin
                    case (b)
                        BYTE_START: w[8*pos +: 16] = {BYTE_ESC_A, BYTE_ESC_A};
                        BYTE_ESC_A: w[8*pos +: 16] = {BYTE_ESC_B, BYTE_ESC_A};
                        BYTE_END:   w[8*pos +: 16] = {BYTE_ESC_F, BYTE_ESC_F};
                        default:    w[8*pos +: 16] = {BYTE_ESC_D, BYTE_ESC_F};
                    endcase
                    pos += 2;
                end
            end else begin
                w[8*pos +: 8] = b;
                pos += 1;
            end
        end
        w[8*pos +: 8] = BYTE_END;
        // broken frames: one byte overwritten
        if (r <= 2)
            w[8*$urandom_range(0, PAYLOAD_BYTES) +: 8] = pick_byte();
        return w;
    endfunction

    task automatic send_request(input logic act, input logic [7:0] cmd,
                                input logic [VALUE_W-1:0] sv, input logic [RX_W-1:0] rx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.action     <= act;
        req_if.command    <= cmd;
        req_if.send_value <= sv;
        req_if.rx_payload <= rx;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        book.note_request(act, cmd, sv, rx);
    endtask

    task automatic send_encode(input logic [7:0] cmd, input logic [VALUE_W-1:0] sv);
        send_request(ACT_ENCODE, cmd, sv, rand_rx());
    endtask

    task automatic send_decode(input logic [RX_W-1:0] rx);
        send_request(ACT_DECODE, 8'($urandom), 16'($urandom), rx);
    endtask

    // response side: checks accepted words and stalls at random
    initial begin : rsp_side
        int stall_left;
        int r;
        bit hold_seen;
        t_result got;
        stall_left = 0;
        hold_seen = 0;
        rsp_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (rsp_if.valid && rsp_if.ready) begin
                got.frame         = rsp_if.frame;
                got.decoded_value = rsp_if.decoded_value;
                got.status        = rsp_if.status;
                book.check_response(got);
            end
            if (hold_off_req && !hold_seen) begin
                hold_seen = 1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if (quiet) begin
                rsp_if.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    stall_left = $urandom_range(0, 2);
                    rsp_if.ready <= 1'b0;
                end else if (r < 10) begin
                    stall_left = $urandom_range(20, 60);
                    rsp_if.ready <= 1'b0;
                end else begin
                    rsp_if.ready <= 1'b1;
                end
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [VALUE_W-1:0] sv;
        book = new;
        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.action     = ACT_ENCODE;
        req_if.command    = '0;
        req_if.send_value = '0;
        req_if.rx_payload = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // encode: extremes and the escaped bytes in both value bytes, all but 8'hFE in the low byte
        send_encode(8'h00, 16'h0000);
        send_encode(8'hFF, 16'hFFFF);
        send_encode(8'hAA, 16'hABAA);
        send_encode(8'h5A, 16'hFEFF);
        send_encode(8'h3C, 16'h12AB);
        send_encode(8'hC3, 16'hFE34);
        send_encode(8'h01, 16'h1234);
        send_encode(8'h80, 16'hAA00);
        // decode: end byte at each place, start byte, late and bad escapes
        send_decode(40'h00_0000_0000);
        send_decode(40'hFF_FFFF_FFFF);
        send_decode(40'hFF_0403_0201);
        send_decode(40'h00_0000_FF12);
        send_decode(40'h00_0000_00AA);
        send_decode(40'h00_00AB_0201);
        send_decode(40'hFF_AB03_0201);
        send_decode(40'h00_FE03_0201);
        send_decode(40'h00_FF05_ABAB);
        send_decode(40'h00_00FF_FDFE);
        send_decode(40'hFF_ACAB_FEFE);
        send_decode(40'hFF_ACAB_0201);
        send_decode(40'hFF_FFFF_12AB);
        send_decode(40'h00_0000_FCFE);
        send_decode(40'h05_0403_0201);
        send_decode(40'h00_0000_AA01);
        send_decode(40'h00_00FF_2211);

        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i == 200) begin
                // long receiver hold-off with the sender running flat out
                quiet = 1;
                hold_off_req = 1;
            end
            if (i == 260)
                quiet = 0;
            if (i == 450) begin
                req_if.valid <= 1'b0;
                while (book.pending() > 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 1) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    sv = {pick_byte(), pick_byte()};
                else
                    sv = 16'($urandom);
                send_encode(8'($urandom), sv);
            end else begin
                send_decode(make_payload());
            end
        end
        req_if.valid <= 1'b0;

        while (book.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        book.report_leftover();

        $display("covered %0d encode and %0d decode words", book.n_enc, book.n_dec);
        $display("decode outcomes: ok %0d, invalid %0d, out of range %0d",
                 book.n_ok, book.n_inv, book.n_rng);
        if (book.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/bsfc_pkg.sv
rtl/bsfc_ifs.sv
rtl/bsfc_encoder.sv
rtl/bsfc_decoder.sv
rtl/byte_stuffed_frame_codec_top.sv
tb/sv/byte_stuffed_frame_codec_top_tb.sv
